FILE: rtl/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg - line edit buffer shared definitions
// Capacity, counter widths, event codes and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int CHAR_W        = 8;
  localparam int KIND_W        = 4;
  localparam int POS_W         = 7;
  // counters hold 0..LINE_CAPACITY
  localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
  // common width for comparing a position input against a counter
  localparam int CMP_W         = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_BACKSPACE = 4'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_LEFT      = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RIGHT     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_HOME      = 4'd5;
  localparam logic [KIND_W-1:0] KIND_END       = 4'd6;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_SET       = 4'd8;
  localparam logic [KIND_W-1:0] KIND_READ      = 4'd9;

  // what every cell does this cycle, relative to position "at"
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_INSERT     = 3'd1,  // above at: take left neighbor, at: load char
    ACT_SHIFT_DOWN = 3'd2,  // at and above: take right neighbor
    ACT_ZERO_FROM  = 3'd3,  // at and above: zero
    ACT_CLEAR      = 3'd4   // every cell: zero
  } act_t;

  typedef struct packed {
    act_t              act;
    logic [CNT_W-1:0]  at;
    logic [CHAR_W-1:0] ch;
  } cell_cmd_t;

endpackage

FILE: rtl/leb_cell.sv
// ----------------------------------------------------------------------------
// leb_cell - one character position of the line
// Holds one character and updates it from its neighbors or the command.
// ----------------------------------------------------------------------------
module leb_cell
  import leb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  idx,
  input  cell_cmd_t         cmd,
  input  logic [CHAR_W-1:0] from_left,
  input  logic [CHAR_W-1:0] from_right,
  output logic [CHAR_W-1:0] data
);

  logic [CHAR_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.act)
      ACT_INSERT: begin
        if (idx > cmd.at) begin
          data_next = from_left;
        end else if (idx == cmd.at) begin
          data_next = cmd.ch;
        end
      end
      ACT_SHIFT_DOWN: begin
        if (idx >= cmd.at) begin
          data_next = from_right;
        end
      end
      ACT_ZERO_FROM: begin
        if (idx >= cmd.at) begin
          data_next = '0;
        end
      end
      ACT_CLEAR: data_next = '0;
      default:   data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/leb_row.sv
// ----------------------------------------------------------------------------
// leb_row - chain of character cells
// Links neighbors for shifting and selects the character at the read position.
// ----------------------------------------------------------------------------
module leb_row
  import leb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_cmd_t         cmd,
  input  logic [CMP_W-1:0]  rd_pos,
  output logic [CHAR_W-1:0] rd_char
);

  logic [CHAR_W-1:0] chars [LINE_CAPACITY];

  for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
    logic [CHAR_W-1:0] left_in;
    logic [CHAR_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = chars[i-1];
    end

    // top cell fills with zero on a left shift
    if (i == LINE_CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = chars[i+1];
    end

    leb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (CNT_W'(i)),
      .cmd        (cmd),
      .from_left  (left_in),
      .from_right (right_in),
      .data       (chars[i])
    );
  end

  // AND-OR select: at most one cell matches
  always_comb begin
    rd_char = '0;
    for (int j = 0; j < LINE_CAPACITY; j++) begin
      if (CMP_W'(j) == rd_pos) begin
        rd_char = rd_char | chars[j];
      end
    end
  end

endmodule

FILE: rtl/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer - bounded line editor with cursor
// Applies one edit event per transaction and reports length, cursor, char.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one edit event per transaction:
//   kind, char_in, position. Output channel (out_valid/out_ready) returns one
//   result per event: line_length, cursor, char_out, ignored.
//   The result is registered and shows on the output in the cycle after the
//   input transaction. Throughput: one event per cycle while the receiver
//   takes each result; every cell of the row loads from its neighbor in the
//   same cycle, so the whole tail shifts together.
//   The input is ready whenever the output register is empty or being taken.
//   If the receiver stalls, the result holds and no further event is taken
//   until it is accepted.
//   Reset (rst, synchronous): the line is emptied, every character cell is
//   zeroed, the cursor returns to 0 and the output register is emptied.
//   Event codes 10 to 15 change nothing and report ignored = 0.
// ----------------------------------------------------------------------------
module line_edit_buffer
  import leb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAR_W-1:0] char_in,
  input  logic [POS_W-1:0]  position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        line_length,
  output logic [6:0]        cursor,
  output logic [CHAR_W-1:0] char_out,
  output logic              ignored
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

  // line state
  logic [CNT_W-1:0]  line_len, line_len_next;
  logic [CNT_W-1:0]  cur_pos, cur_pos_next;

  // output register
  logic [CNT_W-1:0]  res_len, res_cur;
  logic [CHAR_W-1:0] res_char, res_char_next;
  logic              res_ign, res_ign_next;

  logic              in_fire;
  cell_cmd_t         cmd;
  act_t              act;
  logic [CNT_W-1:0]  act_at;
  logic [CMP_W-1:0]  pos_ext, len_ext;
  logic [CHAR_W-1:0] rd_char;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign pos_ext  = CMP_W'(position);
  assign len_ext  = CMP_W'(line_len);

  // event decode: new counters, result and the cell command
  always_comb begin
    line_len_next = line_len;
    cur_pos_next  = cur_pos;
    res_char_next = '0;
    res_ign_next  = 1'b0;
    act           = ACT_NONE;
    act_at        = cur_pos;
    case (kind)
      KIND_INSERT: begin
        if (cur_pos >= CAP) begin
          res_ign_next = 1'b1;
        end else if (char_in == '0) begin
          // zero byte truncates the line at the cursor
          act           = ACT_ZERO_FROM;
          line_len_next = cur_pos;
        end else begin
          act          = ACT_INSERT;
          cur_pos_next = cur_pos + 1'b1;
          if (line_len < CAP) begin
            line_len_next = line_len + 1'b1;
          end
        end
      end
      KIND_BACKSPACE: begin
        if (cur_pos == '0) begin
          res_ign_next = 1'b1;
        end else begin
          act           = ACT_SHIFT_DOWN;
          act_at        = cur_pos - 1'b1;
          line_len_next = line_len - 1'b1;
          cur_pos_next  = cur_pos - 1'b1;
        end
      end
      KIND_DELETE: begin
        // only when a character sits under the cursor
        if (cur_pos >= line_len) begin
          res_ign_next = 1'b1;
        end else begin
          act           = ACT_SHIFT_DOWN;
          line_len_next = line_len - 1'b1;
        end
      end
      KIND_LEFT: begin
        if (cur_pos == '0) begin
          res_ign_next = 1'b1;
        end else begin
          cur_pos_next = cur_pos - 1'b1;
        end
      end
      KIND_RIGHT: begin
        if (cur_pos >= line_len) begin
          res_ign_next = 1'b1;
        end else begin
          cur_pos_next = cur_pos + 1'b1;
        end
      end
      KIND_HOME: cur_pos_next = '0;
      KIND_END:  cur_pos_next = line_len;
      KIND_CLEAR: begin
        act           = ACT_CLEAR;
        line_len_next = '0;
        cur_pos_next  = '0;
      end
      KIND_SET: begin
        // clamp to length
        if (pos_ext > len_ext) begin
          cur_pos_next = line_len;
        end else begin
          cur_pos_next = CNT_W'(pos_ext);
        end
      end
      KIND_READ: begin
        // length never exceeds capacity, so below length is in range
        if (pos_ext < len_ext) begin
          res_char_next = rd_char;
        end
      end
      default: begin
      end
    endcase
  end

  // cells move only on an accepted transaction
  always_comb begin
    cmd.act = in_fire ? act : ACT_NONE;
    cmd.at  = act_at;
    cmd.ch  = char_in;
  end

  leb_row u_row (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_pos  (pos_ext),
    .rd_char (rd_char)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len  <= '0;
      cur_pos   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        line_len  <= line_len_next;
        cur_pos   <= cur_pos_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_len  <= line_len_next;
      res_cur  <= cur_pos_next;
      res_char <= res_char_next;
      res_ign  <= res_ign_next;
    end
  end

  assign line_length = 7'(res_len);
  assign cursor      = 7'(res_cur);
  assign char_out    = res_char;
  assign ignored     = res_ign;

  // cursor never passes the end of the line
  a_cur_le_len: assert property (@(posedge clk) disable iff (rst)
    cur_pos <= line_len)
    else $error("cursor beyond line length");

  a_len_le_cap: assert property (@(posedge clk) disable iff (rst)
    line_len <= CAP)
    else $error("line length beyond capacity");

  // a held result blocks new events
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_insert_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && kind == KIND_INSERT && char_in != '0 && cur_pos < CAP
    |=> cur_pos == $past(cur_pos) + 1'b1 && res_cur == cur_pos)
    else $error("insert did not advance cursor");

endmodule
